[rtl/separable_conv1d_fixed_point_u8_assert.svh]
// assertion macros used by the top-level rtl
`ifndef SEPARABLE_CONV1D_FIXED_POINT_U8_ASSERT_SVH
`define SEPARABLE_CONV1D_FIXED_POINT_U8_ASSERT_SVH

// same-cycle implication
`define SCONV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sconv assertion failed");

// next-cycle implication
`define SCONV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sconv assertion failed");

`endif

[rtl/sconv_pkg.sv]
`default_nettype none
package sconv_pkg;

	localparam int MAX_TAPS   = 12;
	localparam int MAX_STRIDE = 2048;
	localparam int HIST_DEPTH = 32768;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	localparam int PIX_W   = 8;
	localparam int COEF_W  = 16;
	localparam int TAPS_W  = 4;
	localparam int GEOM_W  = 12;
	localparam int COL_W   = 11;
	localparam int ROW_W   = 12;
	localparam int CFG_IW  = 4;
	localparam int CFG_DW  = 64;
	localparam int PROD_W  = PIX_W + COEF_W;
	localparam int ACC_W   = 16;

	localparam logic [CFG_IW-1:0] REG_TAP_COUNT    = 4'd0;
	localparam logic [CFG_IW-1:0] REG_TAP_STEP     = 4'd1;
	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 4'd2;
	localparam logic [CFG_IW-1:0] REG_LINE_STRIDE  = 4'd3;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 4'd4;
	localparam logic [CFG_IW-1:0] REG_COEFS_0_3    = 4'd5;
	localparam logic [CFG_IW-1:0] REG_COEFS_4_7    = 4'd6;
	localparam logic [CFG_IW-1:0] REG_COEFS_8_11   = 4'd7;

	typedef struct packed {
		logic              start;
		logic              issue;
		logic [TAPS_W-1:0] tap_idx;
		logic              load;
	} sconv_cmd_t;

	typedef struct packed {
		logic              need_compute;
		logic [TAPS_W-1:0] taps;
		logic              out_free;
	} sconv_sts_t;

	function automatic logic [COEF_W-1:0] coef_sel(
		input logic [3*CFG_DW-1:0] coefs,
		input logic [TAPS_W-1:0]   idx
	);
		logic [7:0] base;
		base = {idx, 4'b0000};
		if (idx < TAPS_W'(MAX_TAPS)) begin
			coef_sel = coefs[base +: COEF_W];
		end else begin
			coef_sel = '0;
		end
	endfunction

endpackage
`default_nettype wire

[rtl/separable_conv1d_fixed_point_u8.sv]
// Streaming 1-D fixed-point convolution of 8-bit pixels (horizontal or vertical pass).
// Input channel in_valid/in_ready carries pixel_in and start_of_frame, one pixel per beat
// in raster order over lines of line_stride pixels; start_of_frame restarts the frame.
// Output channel out_valid/out_ready carries pixel_out, out_column, out_row and
// end_of_frame; after the end_of_frame beat nothing is produced until the next frame.
// Config channel cfg_valid/cfg_ready (always ready) writes cfg_data to register
// cfg_index: 0 tap_count, 1 tap_step, 2 image_width, 3 line_stride, 4 image_height,
// 5..7 coefficient words. Write config only while the block is idle.
// A pixel that yields no result leaves input open. For a pixel that yields a result,
// with taps being tap_count capped at 12, the block closes input while the taps are
// read from the single-port 32768-entry history ring one per cycle, then a multiply
// stage and the accumulate stage drain, then the result is loaded into the output
// register; when tap_count is 0 it goes straight to the load. A result waiting on a
// stalled receiver holds input closed until the output register frees.
// If out_ready is low, input stays open until a pixel that yields a second result is
// accepted; that result is computed with in_ready low and then waits to load.
// Reset clears counters, positions and config to defaults; the ring is not cleared,
// and no read reaches an entry not yet written in the current frame.
`default_nettype none
module separable_conv1d_fixed_point_u8 (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [sconv_pkg::CFG_IW-1:0]        cfg_index,
	input  wire  [sconv_pkg::CFG_DW-1:0]        cfg_data,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire  [sconv_pkg::PIX_W-1:0]         pixel_in,
	input  wire                                 start_of_frame,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [sconv_pkg::PIX_W-1:0]         pixel_out,
	output logic [sconv_pkg::COL_W-1:0]         out_column,
	output logic [sconv_pkg::ROW_W-1:0]         out_row,
	output logic                                end_of_frame
);

	sconv_pkg::sconv_cmd_t cmd;
	sconv_pkg::sconv_sts_t sts;

	assign cfg_ready = 1'b1;

	sconv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sconv_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel_in       (pixel_in),
		.start_of_frame (start_of_frame),
		.out_ready      (out_ready),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.pixel_out      (pixel_out),
		.out_column     (out_column),
		.out_row        (out_row),
		.end_of_frame   (end_of_frame)
	);

`include "separable_conv1d_fixed_point_u8_assert.svh"

	// never overwrite a result that has not been taken
	`SCONV_ASSERT_NOW(a_load_no_overwrite, clk, arst_n, cmd.load, !out_valid || out_ready)
	// ring reads only while input is closed
	`SCONV_ASSERT_NOW(a_issue_blocks_input, clk, arst_n, cmd.issue, !in_ready)
	// tap index stays within the taps in use
	`SCONV_ASSERT_NOW(a_tap_in_range, clk, arst_n, cmd.issue, cmd.tap_idx < sts.taps)
	// a pixel with no result leaves input open
	`SCONV_ASSERT_NEXT(a_no_result_frees, clk, arst_n,
		in_valid && in_ready && !sts.need_compute, in_ready)

endmodule
`default_nettype wire

[rtl/sconv_ctrl.sv]
`default_nettype none
module sconv_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  sconv_pkg::sconv_sts_t sts,
	output sconv_pkg::sconv_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_ISSUE   = 3'd1;
	localparam logic [2:0] ST_DRAIN_A = 3'd2;
	localparam logic [2:0] ST_DRAIN_B = 3'd3;
	localparam logic [2:0] ST_LOAD    = 3'd4;

	logic [2:0]                    state_q, state_d;
	logic [sconv_pkg::TAPS_W-1:0] tap_q, tap_d;
	logic                          accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd.start   = accept;
		cmd.issue   = (state_q == ST_ISSUE);
		cmd.tap_idx = tap_q;
		cmd.load    = (state_q == ST_LOAD) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		tap_d   = tap_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && sts.need_compute) begin
					tap_d   = '0;
					state_d = (sts.taps == '0) ? ST_LOAD : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (tap_q == sts.taps - sconv_pkg::TAPS_W'(1)) begin
					state_d = ST_DRAIN_A;
				end else begin
					tap_d = tap_q + sconv_pkg::TAPS_W'(1);
				end
			end
			ST_DRAIN_A: state_d = ST_DRAIN_B;
			ST_DRAIN_B: state_d = ST_LOAD;
			ST_LOAD: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

endmodule
`default_nettype wire

[rtl/sconv_dp.sv]
`default_nettype none
module sconv_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	input  wire  [sconv_pkg::CFG_IW-1:0]         cfg_index,
	input  wire  [sconv_pkg::CFG_DW-1:0]         cfg_data,
	input  wire  [sconv_pkg::PIX_W-1:0]          pixel_in,
	input  wire                                  start_of_frame,
	input  wire                                  out_ready,
	input  sconv_pkg::sconv_cmd_t                cmd,
	output sconv_pkg::sconv_sts_t                sts,
	output logic                                 out_valid,
	output logic [sconv_pkg::PIX_W-1:0]          pixel_out,
	output logic [sconv_pkg::COL_W-1:0]          out_column,
	output logic [sconv_pkg::ROW_W-1:0]          out_row,
	output logic                                 end_of_frame
);

	localparam int AW = sconv_pkg::HIST_AW;
	localparam int GW = sconv_pkg::GEOM_W;
	localparam int TW = sconv_pkg::TAPS_W;

	// configuration
	logic [TW-1:0]                   tap_count_q;
	logic [GW-1:0]                   tap_step_q, img_w_q, stride_q, img_h_q;
	logic [3*sconv_pkg::CFG_DW-1:0] coefs_q;

	// frame state
	logic [AW-1:0]                   wr_idx_q, fill_q;
	logic [sconv_pkg::COL_W-1:0]    col_q;
	logic [sconv_pkg::ROW_W-1:0]    row_q;
	logic                            done_q;

	// history ring
	logic [sconv_pkg::PIX_W-1:0]    ring_q [sconv_pkg::HIST_DEPTH];

	// tap datapath
	logic [AW-1:0]                   addr_q;
	logic [sconv_pkg::PIX_W-1:0]    rd_s1;
	logic [sconv_pkg::COEF_W-1:0]   coef_s1;
	logic                            v_s1, v_s2;
	logic [sconv_pkg::PROD_W-1:0]   prod_s2;
	logic [sconv_pkg::ACC_W-1:0]    acc_q;
	logic [sconv_pkg::ACC_W:0]      acc_sum;

	// result held for the output
	logic [sconv_pkg::COL_W-1:0]    res_col_q;
	logic [sconv_pkg::ROW_W-1:0]    res_row_q;
	logic                            res_eof_q;
	logic                            out_valid_q;
	logic [sconv_pkg::PIX_W-1:0]    pix_out_q;
	logic [sconv_pkg::COL_W-1:0]    col_out_q;
	logic [sconv_pkg::ROW_W-1:0]    row_out_q;
	logic                            eof_out_q;

	logic [TW-1:0]  taps_eff, taps_m1;
	logic [GW-1:0]  step_eff, stride_eff, last_col;
	logic [15:0]    lag;
	logic [AW-1:0]  newest, fill_cur;
	logic [sconv_pkg::COL_W-1:0] col_cur;
	logic [sconv_pkg::ROW_W-1:0] row_cur;
	logic           done_cur, filling, in_range, is_eof, produce, advance, wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TW'(1);
			tap_step_q  <= GW'(1);
			img_w_q     <= GW'(1);
			stride_q    <= GW'(1);
			img_h_q     <= GW'(1);
			coefs_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sconv_pkg::REG_TAP_COUNT:    tap_count_q <= cfg_data[TW-1:0];
				sconv_pkg::REG_TAP_STEP:     tap_step_q  <= cfg_data[GW-1:0];
				sconv_pkg::REG_IMAGE_WIDTH:  img_w_q     <= cfg_data[GW-1:0];
				sconv_pkg::REG_LINE_STRIDE:  stride_q    <= cfg_data[GW-1:0];
				sconv_pkg::REG_IMAGE_HEIGHT: img_h_q     <= cfg_data[GW-1:0];
				sconv_pkg::REG_COEFS_0_3:    coefs_q[63:0]    <= cfg_data;
				sconv_pkg::REG_COEFS_4_7:    coefs_q[127:64]  <= cfg_data;
				sconv_pkg::REG_COEFS_8_11:   coefs_q[191:128] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		taps_eff   = (tap_count_q > TW'(sconv_pkg::MAX_TAPS)) ?
			TW'(sconv_pkg::MAX_TAPS) : tap_count_q;
		step_eff   = (tap_step_q > GW'(sconv_pkg::MAX_STRIDE)) ?
			GW'(sconv_pkg::MAX_STRIDE) : tap_step_q;
		stride_eff = (stride_q == '0) ? GW'(1) :
			((stride_q > GW'(sconv_pkg::MAX_STRIDE)) ? GW'(sconv_pkg::MAX_STRIDE) : stride_q);
		taps_m1    = (taps_eff == '0) ? '0 : taps_eff - TW'(1);
		lag        = {12'd0, taps_m1} * {4'd0, step_eff};
		last_col   = ((img_w_q < stride_eff) ? img_w_q : stride_eff) - GW'(1);

		newest   = start_of_frame ? '0 : wr_idx_q;
		fill_cur = start_of_frame ? '0 : fill_q;
		col_cur  = start_of_frame ? '0 : col_q;
		row_cur  = start_of_frame ? '0 : row_q;
		done_cur = start_of_frame ? 1'b0 : done_q;

		filling  = {1'b0, fill_cur} < lag;
		in_range = ({1'b0, col_cur} < img_w_q) && (row_cur < img_h_q);
		is_eof   = (row_cur == img_h_q - GW'(1)) && ({1'b0, col_cur} == last_col);
		produce  = !filling && !done_cur && in_range;
		advance  = !filling && !done_cur && !(produce && is_eof);
		wrap     = ({1'b0, col_cur} + GW'(1)) >= stride_eff;
	end

	always_comb begin
		sts.need_compute = produce;
		sts.taps         = taps_eff;
		sts.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			fill_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			done_q   <= 1'b0;
		end else if (cmd.start) begin
			wr_idx_q <= newest + AW'(1);
			fill_q   <= filling ? fill_cur + AW'(1) : fill_cur;
			done_q   <= done_cur || (produce && is_eof);
			if (advance && wrap) begin
				col_q <= '0;
				row_q <= row_cur + sconv_pkg::ROW_W'(1);
			end else if (advance) begin
				col_q <= col_cur + sconv_pkg::COL_W'(1);
				row_q <= row_cur;
			end else begin
				col_q <= col_cur;
				row_q <= row_cur;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ring_q[newest] <= pixel_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_s1 <= ring_q[addr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q    <= newest - lag[AW-1:0];
			res_col_q <= col_cur;
			res_row_q <= row_cur;
			res_eof_q <= is_eof;
		end else if (cmd.issue) begin
			addr_q <= addr_q + AW'(step_eff);
		end
		coef_s1 <= sconv_pkg::coef_sel(coefs_q, cmd.tap_idx);
		prod_s2 <= {{sconv_pkg::COEF_W{1'b0}}, rd_s1} * {{sconv_pkg::PIX_W{1'b0}}, coef_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// saturating 16-bit accumulate of the shifted products
	assign acc_sum = {1'b0, acc_q} + {{(sconv_pkg::ACC_W + 1 - sconv_pkg::PIX_W){1'b0}},
		prod_s2[sconv_pkg::PROD_W-1:sconv_pkg::COEF_W]};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_sum[sconv_pkg::ACC_W] ? '1 : acc_sum[sconv_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_out_q <= (acc_q > sconv_pkg::ACC_W'(255)) ? '1 : acc_q[sconv_pkg::PIX_W-1:0];
			col_out_q <= res_col_q;
			row_out_q <= res_row_q;
			eof_out_q <= res_eof_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_out    = pix_out_q;
	assign out_column   = col_out_q;
	assign out_row      = row_out_q;
	assign end_of_frame = eof_out_q;

endmodule
`default_nettype wire
